[hdl/cbc_pkg.sv]
package cbc_pkg;

	localparam int DEF_MAX_COLUMNS = 4096;
	localparam int DEF_MAX_ROWS    = 4096;

	localparam int CFG_W   = 13;
	localparam int HSV_W   = 24;
	localparam int IDX_W   = 3;
	localparam int SUM_W   = 36;
	localparam int CNT_W   = 25;
	localparam int QUEUE_DEPTH = 4;

	localparam logic [IDX_W-1:0] REG_BOX_LEFT   = 3'd0;
	localparam logic [IDX_W-1:0] REG_BOX_TOP    = 3'd1;
	localparam logic [IDX_W-1:0] REG_BOX_WIDTH  = 3'd2;
	localparam logic [IDX_W-1:0] REG_BOX_HEIGHT = 3'd3;
	localparam logic [IDX_W-1:0] REG_FRAME_COLS = 3'd4;
	localparam logic [IDX_W-1:0] REG_FRAME_ROWS = 3'd5;
	localparam logic [IDX_W-1:0] REG_HSV_LOWER  = 3'd6;
	localparam logic [IDX_W-1:0] REG_HSV_UPPER  = 3'd7;

	// queued pixel: color, box membership, frame-end flag, box-relative position, box origin
	typedef struct packed {
		logic [7:0]       blue;
		logic [7:0]       green;
		logic [7:0]       red;
		logic             in_box;
		logic             frame_end;
		logic [CFG_W-1:0] rel_col;
		logic [CFG_W-1:0] rel_row;
		logic [CFG_W-1:0] org_col;
		logic [CFG_W-1:0] org_row;
	} cbc_entry_t;

endpackage

[hdl/cbc_front.sv]
module cbc_front import cbc_pkg::*; #(
	parameter int MAX_COLUMNS = DEF_MAX_COLUMNS,
	parameter int MAX_ROWS    = DEF_MAX_ROWS
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    in_valid,
	output logic                    in_ready,
	input  logic [7:0]              pix_blue,
	input  logic [7:0]              pix_green,
	input  logic [7:0]              pix_red,
	input  logic                    frame_end,
	input  logic signed [CFG_W-1:0] box_left,
	input  logic signed [CFG_W-1:0] box_top,
	input  logic [CFG_W-1:0]        box_width,
	input  logic [CFG_W-1:0]        box_height,
	input  logic [CFG_W-1:0]        frame_columns,
	input  logic [CFG_W-1:0]        frame_rows,
	input  logic                    q_full,
	output logic                    q_push,
	output cbc_entry_t              q_data
);
	localparam int CW = $clog2(MAX_COLUMNS);
	localparam int RW = $clog2(MAX_ROWS);
	localparam logic signed [15:0] MAXC = 16'(MAX_COLUMNS);
	localparam logic signed [15:0] MAXR = 16'(MAX_ROWS);
	localparam logic [RW-1:0] ROW_LAST = RW'(MAX_ROWS - 1);

	logic [CW-1:0] col_q;
	logic [RW-1:0] row_q;
	logic signed [15:0] cols, rows, x0, y0, w, h, c, r, cnext;
	logic in_box;

	always_comb begin
		cols = $signed({3'b000, frame_columns});
		if (cols < 16'sd1) cols = 16'sd1;
		if (cols > MAXC) cols = MAXC;
		rows = $signed({3'b000, frame_rows});
		if (rows < 16'sd1) rows = 16'sd1;
		if (rows > MAXR) rows = MAXR;
		x0 = box_left[CFG_W-1] ? 16'sd0 : $signed({3'b000, box_left});
		y0 = box_top[CFG_W-1] ? 16'sd0 : $signed({3'b000, box_top});
		w = $signed({3'b000, box_width});
		h = $signed({3'b000, box_height});
		if (x0 + w >= cols) w = cols - 16'sd1 - x0;
		if (y0 + h >= rows) h = rows - 16'sd1 - y0;
		c = $signed(16'(col_q));
		r = $signed(16'(row_q));
		cnext = c + 16'sd1;
		in_box = (w > 16'sd0) && (h > 16'sd0) && (c >= x0) && (c < x0 + w)
			&& (r >= y0) && (r < y0 + h);
	end

	assign in_ready = !q_full;
	assign q_push   = in_valid && !q_full;

	always_comb begin
		q_data.blue      = pix_blue;
		q_data.green     = pix_green;
		q_data.red       = pix_red;
		q_data.in_box    = in_box;
		q_data.frame_end = frame_end;
		q_data.rel_col   = CFG_W'(c - x0);
		q_data.rel_row   = CFG_W'(r - y0);
		q_data.org_col   = CFG_W'(x0);
		q_data.org_row   = CFG_W'(y0);
	end

	// advance the raster position; restart at frame end
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
		end else if (q_push) begin
			if (frame_end) begin
				col_q <= '0;
				row_q <= '0;
			end else if (cnext >= cols) begin
				col_q <= '0;
				if (row_q != ROW_LAST) row_q <= row_q + 1'b1;
			end else begin
				col_q <= CW'(cnext);
			end
		end
	end
endmodule

[hdl/cbc_queue.sv]
module cbc_queue import cbc_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       push,
	input  cbc_entry_t push_data,
	output logic       full,
	input  logic       pop,
	output logic       not_empty,
	output cbc_entry_t head
);
	localparam int PW = $clog2(QUEUE_DEPTH);

	cbc_entry_t mem_q [QUEUE_DEPTH];
	logic [PW-1:0] wr_q, rd_q;
	logic [PW:0]   cnt_q;

	assign full      = (cnt_q == (PW+1)'(QUEUE_DEPTH));
	assign not_empty = (cnt_q != '0);
	assign head      = mem_q[rd_q];

	always_ff @(posedge clk) begin
		if (push) mem_q[wr_q] <= push_data;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) wr_q <= wr_q + 1'b1;
			if (pop) rd_q <= rd_q + 1'b1;
			if (push && !pop) cnt_q <= cnt_q + 1'b1;
			else if (pop && !push) cnt_q <= cnt_q - 1'b1;
		end
	end
endmodule

[hdl/cbc_div.sv]
module cbc_div import cbc_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             go,
	input  logic [SUM_W-1:0] num,
	input  logic [CNT_W-1:0] den,
	output logic             done,
	output logic [SUM_W-1:0] quot
);
	localparam int SW = $clog2(SUM_W + 1);

	logic [SUM_W-1:0] quot_q;
	logic [CNT_W:0]   rem_q;
	logic [CNT_W-1:0] den_q;
	logic [SW-1:0]    step_q;
	logic             busy_q, done_q;
	logic [CNT_W+1:0] trial;

	assign trial = {rem_q, quot_q[SUM_W-1]} - {2'b00, den_q};
	assign done  = done_q;
	assign quot  = quot_q;

	// restoring division, one quotient bit a cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			step_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (go) begin
				busy_q <= 1'b1;
				step_q <= SW'(SUM_W);
			end else if (busy_q) begin
				step_q <= step_q - 1'b1;
				if (step_q == SW'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (go) begin
			quot_q <= num;
			rem_q  <= '0;
			den_q  <= den;
		end else if (busy_q) begin
			if (!trial[CNT_W+1]) begin
				rem_q  <= trial[CNT_W:0];
				quot_q <= {quot_q[SUM_W-2:0], 1'b1};
			end else begin
				rem_q  <= {rem_q[CNT_W-1:0], quot_q[SUM_W-1]};
				quot_q <= {quot_q[SUM_W-2:0], 1'b0};
			end
		end
	end
endmodule

[hdl/cbc_back.sv]
module cbc_back import cbc_pkg::*; (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    q_not_empty,
	input  cbc_entry_t              q_head,
	output logic                    q_pop,
	input  logic [HSV_W-1:0]        hsv_lower,
	input  logic [HSV_W-1:0]        hsv_upper,
	output logic                    out_valid,
	input  logic                    out_ready,
	output logic signed [CFG_W-1:0] head_col,
	output logic signed [CFG_W-1:0] head_row,
	output logic                    found
);
	localparam logic [3:0] ST_IDLE = 4'd0;
	localparam logic [3:0] ST_SDIV = 4'd1;
	localparam logic [3:0] ST_HDIV = 4'd2;
	localparam logic [3:0] ST_SMUL = 4'd3;
	localparam logic [3:0] ST_HMUL = 4'd4;
	localparam logic [3:0] ST_CLS  = 4'd5;
	localparam logic [3:0] ST_FIN  = 4'd6;
	localparam logic [3:0] ST_CDIV = 4'd7;
	localparam logic [3:0] ST_RDIV = 4'd8;
	localparam logic [3:0] ST_OUT  = 4'd9;

	localparam logic [SUM_W-1:0] SAT_NUM = SUM_W'(2 * 255 * 4096);
	localparam logic [SUM_W-1:0] HUE_NUM = SUM_W'(2 * 30 * 4096);

	logic [3:0] state_q;
	logic [7:0] mx, mn, diff;
	logic signed [11:0] hv;
	logic [7:0] mx_q, diff_q;
	logic signed [11:0] hv_q;
	logic [CFG_W-1:0] rc_q, rr_q, oc_q, or_q;
	logic fe_q;
	logic [21:0] sdiv_q;
	logic [16:0] hdiv_q;
	logic [29:0] sprod_q;
	logic signed [30:0] hprod_q;
	logic [SUM_W-1:0] sum_c_q, sum_r_q;
	logic [CNT_W-1:0] cnt_q;
	logic [CFG_W-1:0] mcol_q;
	logic signed [CFG_W-1:0] rcol_q, rrow_q;
	logic rfound_q;
	logic out_valid_q;
	logic signed [CFG_W-1:0] oc_out_q, or_out_q;
	logic found_q;

	logic go_q;
	logic [SUM_W-1:0] num_q;
	logic [CNT_W-1:0] den_q;
	logic div_done;
	logic [SUM_W-1:0] quot;

	logic [17:0] s_val;
	logic signed [18:0] t_val, h_val;
	logic hit;
	logic [CFG_W-1:0] mrow;

	cbc_div u_div (
		.clk(clk), .arst_n(arst_n), .go(go_q), .num(num_q), .den(den_q),
		.done(div_done), .quot(quot)
	);

	always_comb begin
		mx = q_head.blue;
		mn = q_head.blue;
		if (q_head.green > mx) mx = q_head.green;
		if (q_head.red > mx) mx = q_head.red;
		if (q_head.green < mn) mn = q_head.green;
		if (q_head.red < mn) mn = q_head.red;
		diff = mx - mn;
		if (mx == q_head.red)
			hv = $signed({4'b0, q_head.green}) - $signed({4'b0, q_head.blue});
		else if (mx == q_head.green)
			hv = $signed({4'b0, q_head.blue}) - $signed({4'b0, q_head.red})
				+ $signed({3'b0, diff, 1'b0});
		else
			hv = $signed({4'b0, q_head.red}) - $signed({4'b0, q_head.green})
				+ $signed({2'b0, diff, 2'b0});
	end

	always_comb begin
		s_val = 18'((sprod_q + 30'd2048) >> 12);
		t_val = 19'((hprod_q + 31'sd2048) >>> 12);
		h_val = (t_val < 0) ? t_val + 19'sd180 : t_val;
		hit = (h_val >= $signed({11'b0, hsv_lower[23:16]}))
			&& (h_val <= $signed({11'b0, hsv_upper[23:16]}))
			&& (s_val >= {10'b0, hsv_lower[15:8]}) && (s_val <= {10'b0, hsv_upper[15:8]})
			&& (mx_q >= hsv_lower[7:0]) && (mx_q <= hsv_upper[7:0]);
	end

	assign mrow      = quot[CFG_W-1:0];
	assign q_pop     = (state_q == ST_IDLE) && q_not_empty;
	assign out_valid = out_valid_q;
	assign head_col  = oc_out_q;
	assign head_row  = or_out_q;
	assign found     = found_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			go_q        <= 1'b0;
			sum_c_q     <= '0;
			sum_r_q     <= '0;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (state_q == ST_OUT && (!out_valid_q || out_ready)) out_valid_q <= 1'b1;
			else if (out_valid_q && out_ready) out_valid_q <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					go_q <= q_not_empty && q_head.in_box && (mx != 8'd0);
					if (q_not_empty) begin
						if (q_head.in_box) begin
							if (mx != 8'd0) begin
								state_q <= ST_SDIV;
							end else begin
								state_q <= ST_SMUL;
							end
						end else if (q_head.frame_end) begin
							state_q <= ST_FIN;
						end
					end
				end
				ST_SDIV: begin
					go_q <= div_done && (diff_q != 8'd0);
					if (div_done) begin
						if (diff_q != 8'd0) begin
							state_q <= ST_HDIV;
						end else begin
							state_q <= ST_SMUL;
						end
					end
				end
				ST_HDIV: begin
					go_q <= 1'b0;
					if (div_done) state_q <= ST_SMUL;
				end
				ST_SMUL: begin
					go_q    <= 1'b0;
					state_q <= ST_HMUL;
				end
				ST_HMUL: begin
					go_q    <= 1'b0;
					state_q <= ST_CLS;
				end
				ST_CLS: begin
					go_q <= 1'b0;
					if (hit) begin
						sum_c_q <= sum_c_q + SUM_W'(rc_q);
						sum_r_q <= sum_r_q + SUM_W'(rr_q);
						cnt_q   <= cnt_q + 1'b1;
					end
					state_q <= fe_q ? ST_FIN : ST_IDLE;
				end
				ST_FIN: begin
					go_q <= (cnt_q != '0);
					if (cnt_q == '0) begin
						state_q <= ST_OUT;
					end else begin
						state_q <= ST_CDIV;
					end
				end
				ST_CDIV: begin
					go_q <= div_done;
					if (div_done) state_q <= ST_RDIV;
				end
				ST_RDIV: begin
					go_q <= 1'b0;
					if (div_done) state_q <= ST_OUT;
				end
				ST_OUT: begin
					go_q <= 1'b0;
					if (!out_valid_q || out_ready) begin
						sum_c_q <= '0;
						sum_r_q <= '0;
						cnt_q   <= '0;
						state_q <= ST_IDLE;
					end
				end
				default: begin
					go_q    <= 1'b0;
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				mx_q   <= mx;
				diff_q <= diff;
				hv_q   <= hv;
				rc_q   <= q_head.rel_col;
				rr_q   <= q_head.rel_row;
				oc_q   <= q_head.org_col;
				or_q   <= q_head.org_row;
				fe_q   <= q_head.frame_end;
				sdiv_q <= '0;
				hdiv_q <= '0;
				num_q  <= SAT_NUM + SUM_W'(mx);
				den_q  <= CNT_W'({mx, 1'b0});
			end
			ST_SDIV: begin
				if (div_done) begin
					sdiv_q <= quot[21:0];
					num_q  <= HUE_NUM + SUM_W'(diff_q);
					den_q  <= CNT_W'({diff_q, 1'b0});
				end
			end
			ST_HDIV: begin
				if (div_done) hdiv_q <= quot[16:0];
			end
			ST_SMUL: sprod_q <= 30'(diff_q * sdiv_q);
			ST_HMUL: hprod_q <= 31'(hv_q * $signed({1'b0, hdiv_q}));
			ST_FIN: begin
				num_q    <= sum_c_q;
				den_q    <= cnt_q;
				rcol_q   <= '1;
				rrow_q   <= '1;
				rfound_q <= 1'b0;
			end
			ST_CDIV: begin
				if (div_done) begin
					mcol_q <= quot[CFG_W-1:0];
					num_q  <= sum_r_q;
				end
			end
			ST_RDIV: begin
				if (div_done) begin
					rfound_q <= 1'b1;
					// a zero mean on either axis sends both to one short of the box origin
					if (mcol_q == '0 || mrow == '0) begin
						rcol_q <= $signed(oc_q - 1'b1);
						rrow_q <= $signed(or_q - 1'b1);
					end else begin
						rcol_q <= $signed(mcol_q + oc_q);
						rrow_q <= $signed(mrow + or_q);
					end
				end
			end
			ST_OUT: begin
				if (!out_valid_q || out_ready) begin
					oc_out_q <= rcol_q;
					or_out_q <= rrow_q;
					found_q  <= rfound_q;
				end
			end
			default: ;
		endcase
	end
endmodule

[hdl/hsv_color_blob_centroid_unit.sv]
// HSV color blob centroid. Feed one frame of BGR pixels in raster order and
// mark the last one with frame_end; one beat of head_col/head_row/found comes
// out per frame. The front takes a pixel beat every cycle while its 4-entry
// queue has room and tags it with its search-box position. The back converts
// each in-box pixel to HSV through one shared 36-step serial divider: a colored
// pixel inside the box takes two divisions plus multiply and classify, a gray one
// skips the hue division, a black one skips both divisions, and a pixel outside
// the box is only popped; frame end adds the two centroid divisions (none when
// nothing matched). Write registers only while idle.
module hsv_color_blob_centroid_unit import cbc_pkg::*; #(
	parameter int MAX_COLUMNS = DEF_MAX_COLUMNS,
	parameter int MAX_ROWS    = DEF_MAX_ROWS
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    cfg_we,
	input  logic [IDX_W-1:0]        cfg_index,
	input  logic [HSV_W-1:0]        cfg_data,
	input  logic                    in_valid,
	output logic                    in_ready,
	input  logic [7:0]              pix_blue,
	input  logic [7:0]              pix_green,
	input  logic [7:0]              pix_red,
	input  logic                    frame_end,
	output logic                    out_valid,
	input  logic                    out_ready,
	output logic signed [CFG_W-1:0] head_col,
	output logic signed [CFG_W-1:0] head_row,
	output logic                    found
);
	logic signed [CFG_W-1:0] box_left_q, box_top_q;
	logic [CFG_W-1:0] box_width_q, box_height_q, frame_cols_q, frame_rows_q;
	logic [HSV_W-1:0] hsv_lower_q, hsv_upper_q;

	logic       q_full, q_push, q_pop, q_not_empty;
	cbc_entry_t q_wdata, q_head;

	// hold configuration; reset values give a 640x480 frame and a yellow hue band
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			box_left_q   <= '0;
			box_top_q    <= '0;
			box_width_q  <= '0;
			box_height_q <= '0;
			frame_cols_q <= CFG_W'(640);
			frame_rows_q <= CFG_W'(480);
			hsv_lower_q  <= HSV_W'(877668);
			hsv_upper_q  <= HSV_W'(2223048);
		end else if (cfg_we) begin
			case (cfg_index)
				REG_BOX_LEFT:   box_left_q   <= $signed(cfg_data[CFG_W-1:0]);
				REG_BOX_TOP:    box_top_q    <= $signed(cfg_data[CFG_W-1:0]);
				REG_BOX_WIDTH:  box_width_q  <= cfg_data[CFG_W-1:0];
				REG_BOX_HEIGHT: box_height_q <= cfg_data[CFG_W-1:0];
				REG_FRAME_COLS: frame_cols_q <= cfg_data[CFG_W-1:0];
				REG_FRAME_ROWS: frame_rows_q <= cfg_data[CFG_W-1:0];
				REG_HSV_LOWER:  hsv_lower_q  <= cfg_data;
				REG_HSV_UPPER:  hsv_upper_q  <= cfg_data;
				default: ;
			endcase
		end
	end

	// front: raster position and box test
	cbc_front #(.MAX_COLUMNS(MAX_COLUMNS), .MAX_ROWS(MAX_ROWS)) u_front (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready),
		.pix_blue(pix_blue), .pix_green(pix_green), .pix_red(pix_red),
		.frame_end(frame_end),
		.box_left(box_left_q), .box_top(box_top_q),
		.box_width(box_width_q), .box_height(box_height_q),
		.frame_columns(frame_cols_q), .frame_rows(frame_rows_q),
		.q_full(q_full), .q_push(q_push), .q_data(q_wdata)
	);

	// decouple the front, one pixel per cycle while the queue has room, from the serial back
	cbc_queue u_queue (
		.clk(clk), .arst_n(arst_n),
		.push(q_push), .push_data(q_wdata), .full(q_full),
		.pop(q_pop), .not_empty(q_not_empty), .head(q_head)
	);

	// back: HSV conversion, accumulation and centroid
	cbc_back u_back (
		.clk(clk), .arst_n(arst_n),
		.q_not_empty(q_not_empty), .q_head(q_head), .q_pop(q_pop),
		.hsv_lower(hsv_lower_q), .hsv_upper(hsv_upper_q),
		.out_valid(out_valid), .out_ready(out_ready),
		.head_col(head_col), .head_row(head_row), .found(found)
	);
endmodule

[tb/hsv_color_blob_centroid_unit_tb.sv]
module hsv_color_blob_centroid_unit_tb;
	import cbc_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int LIMIT_COLS = 4096;
	localparam int LIMIT_ROWS = 4096;
	// long enough for a full input queue of in-box pixels plus the frame-end divisions
	localparam int DRAIN_CYCLES = 600;
	localparam int HOLD_CYCLES = 800;

	typedef struct {
		logic [7:0] blue;
		logic [7:0] green;
		logic [7:0] red;
		logic       last;
	} pixel_t;

	typedef struct {
		logic signed [CFG_W-1:0] col;
		logic signed [CFG_W-1:0] row;
		logic                    hit;
	} centroid_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we = 1'b0;
	logic [IDX_W-1:0] cfg_index = '0;
	logic [HSV_W-1:0] cfg_data = '0;
	logic in_valid = 1'b0;
	logic in_ready;
	logic [7:0] pix_blue = '0, pix_green = '0, pix_red = '0;
	logic frame_end = 1'b0;
	logic out_valid;
	logic out_ready = 1'b0;
	logic signed [CFG_W-1:0] head_col, head_row;
	logic found;

	hsv_color_blob_centroid_unit dut (.*);

	always #1 clk = ~clk;

	// shadow copy of the register file and the accumulation state
	int box_x, box_y, box_w, box_h, fcols, frows;
	logic [23:0] lo_bound, hi_bound;
	int pos_col, pos_row;
	logic [35:0] acc_cols, acc_rows;
	logic [24:0] hit_count;

	pixel_t pending_pixels[$];
	centroid_t centroid_queue[$];
	int fail_count = 0;
	int pixels_taken = 0;
	int frames_checked = 0;
	int frames_found = 0;
	bit quiet = 1'b0;
	bit hold_req = 1'b0;
	bit hold_done = 1'b0;

	function automatic logic [23:0] to_hsv(int b, int g, int r);
		int mx, mn, diff, hv, s;
		longint sdiv, hdiv, t;
		mx = b; mn = b;
		if (g > mx) mx = g;
		if (r > mx) mx = r;
		if (g < mn) mn = g;
		if (r < mn) mn = r;
		diff = mx - mn;
		sdiv = (mx > 0) ? (2 * longint'(255 << 12) + mx) / (2 * longint'(mx)) : 0;
		hdiv = (diff > 0) ? (2 * longint'(30 * 4096) + diff) / (2 * longint'(diff)) : 0;
		s = int'((longint'(diff) * sdiv + 2048) / 4096);
		if (mx == r) hv = g - b;
		else if (mx == g) hv = b - r + 2 * diff;
		else hv = r - g + 4 * diff;
		t = longint'(hv) * hdiv + 2048;
		// floor toward minus infinity
		t = (t >= 0) ? t / 4096 : -((-t + 4095) / 4096);
		if (t < 0) t += 180;
		return {t[7:0], s[7:0], mx[7:0]};
	endfunction

	function automatic bit in_range(logic [7:0] x, logic [7:0] lo, logic [7:0] hi);
		return x >= lo && x <= hi;
	endfunction

	task automatic predict_pixel(pixel_t p);
		int cols, rows, x0, y0, w, h;
		logic [23:0] hsv;
		longint mc, mr;
		centroid_t res;
		cols = fcols < 1 ? 1 : (fcols > LIMIT_COLS ? LIMIT_COLS : fcols);
		rows = frows < 1 ? 1 : (frows > LIMIT_ROWS ? LIMIT_ROWS : frows);
		x0 = box_x < 0 ? 0 : box_x;
		y0 = box_y < 0 ? 0 : box_y;
		w = box_w;
		h = box_h;
		// right and bottom edges stop one short of the border
		if (x0 + w >= cols) w = cols - 1 - x0;
		if (y0 + h >= rows) h = rows - 1 - y0;
		if (w > 0 && h > 0 && pos_col >= x0 && pos_col < x0 + w &&
				pos_row >= y0 && pos_row < y0 + h) begin
			hsv = to_hsv(p.blue, p.green, p.red);
			if (in_range(hsv[23:16], lo_bound[23:16], hi_bound[23:16]) &&
					in_range(hsv[15:8], lo_bound[15:8], hi_bound[15:8]) &&
					in_range(hsv[7:0], lo_bound[7:0], hi_bound[7:0])) begin
				acc_cols = acc_cols + 36'(pos_col - x0);
				acc_rows = acc_rows + 36'(pos_row - y0);
				hit_count = hit_count + 25'd1;
			end
		end
		pos_col++;
		if (pos_col >= cols) begin
			pos_col = 0;
			if (pos_row < LIMIT_ROWS - 1) pos_row++;
		end
		if (p.last) begin
			mc = -1;
			mr = -1;
			res.hit = 1'b0;
			if (hit_count != 0) begin
				mc = longint'(acc_cols / hit_count);
				mr = longint'(acc_rows / hit_count);
				// a zero mean on either axis collapses both to -1
				if (mc == 0 || mr == 0) begin
					mc = -1;
					mr = -1;
				end
				mc += x0;
				mr += y0;
				res.hit = 1'b1;
			end
			res.col = mc[CFG_W-1:0];
			res.row = mr[CFG_W-1:0];
			centroid_queue.push_back(res);
			pos_col = 0;
			pos_row = 0;
			acc_cols = '0;
			acc_rows = '0;
			hit_count = '0;
		end
	endtask

	// monitor: sample both handshakes at the rising edge
	always @(posedge clk) begin
		centroid_t want;
		if (arst_n && out_valid && out_ready) begin
			if (centroid_queue.size() == 0) begin
				$error("unexpected result beat col=%0d row=%0d found=%0b", head_col, head_row,
					found);
				fail_count++;
			end else begin
				want = centroid_queue.pop_front();
				frames_checked++;
				if (want.hit) frames_found++;
				if (head_col !== want.col) begin
					$error("head_col expected %0d actual %0d", want.col, head_col);
					fail_count++;
				end
				if (head_row !== want.row) begin
					$error("head_row expected %0d actual %0d", want.row, head_row);
					fail_count++;
				end
				if (found !== want.hit) begin
					$error("found expected %0b actual %0b", want.hit, found);
					fail_count++;
				end
			end
		end
		if (arst_n && in_valid && in_ready) begin
			predict_pixel('{pix_blue, pix_green, pix_red, frame_end});
			pixels_taken++;
		end
	end

	// driver: change inputs on the falling edge, hold a beat until taken
	bit beat_taken;
	int src_gap = 0;
	always @(posedge clk) beat_taken <= in_valid && in_ready;

	always @(negedge clk) begin
		pixel_t p;
		if (arst_n && (!in_valid || beat_taken)) begin
			if (src_gap > 0) begin
				in_valid <= 1'b0;
				src_gap--;
			end else if (pending_pixels.size() > 0) begin
				p = pending_pixels.pop_front();
				in_valid <= 1'b1;
				pix_blue <= p.blue;
				pix_green <= p.green;
				pix_red <= p.red;
				frame_end <= p.last;
				if (!quiet && $urandom_range(0, 7) == 0) src_gap = $urandom_range(1, 19);
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// sink: random stall bursts, plus one long hold-off on request
	int sink_gap = 0;
	int hold_left = 0;
	always @(negedge clk) begin
		if (arst_n) begin
			if (hold_req && !hold_done) begin
				hold_done = 1'b1;
				hold_left = HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				out_ready <= 1'b0;
				hold_left--;
			end else if (sink_gap > 0) begin
				out_ready <= 1'b0;
				sink_gap--;
			end else begin
				out_ready <= 1'b1;
				if (!quiet && $urandom_range(0, 9) == 0) sink_gap = $urandom_range(1, 19);
			end
		end
	end

	task automatic write_reg(logic [IDX_W-1:0] idx, logic [HSV_W-1:0] val);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		case (idx)
			REG_BOX_LEFT: box_x = int'($signed(val[12:0]));
			REG_BOX_TOP: box_y = int'($signed(val[12:0]));
			REG_BOX_WIDTH: box_w = int'(val[12:0]);
			REG_BOX_HEIGHT: box_h = int'(val[12:0]);
			REG_FRAME_COLS: fcols = int'(val[12:0]);
			REG_FRAME_ROWS: frows = int'(val[12:0]);
			REG_HSV_LOWER: lo_bound = val;
			REG_HSV_UPPER: hi_bound = val;
			default: ;
		endcase
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	// wait until every queued pixel is taken and every result is back, then drain
	task automatic settle();
		while (pending_pixels.size() > 0 || in_valid || centroid_queue.size() > 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	// 13-bit register value, sometimes with noise in the unused upper bits
	function automatic logic [HSV_W-1:0] reg13(int v);
		logic [HSV_W-1:0] d;
		d = {$urandom} & 24'hFFE000;
		if ($urandom_range(0, 3) != 0) d = '0;
		return d | 24'(v & 16'h1FFF);
	endfunction

	function automatic pixel_t random_pixel(bit last);
		pixel_t p;
		case ($urandom_range(0, 5))
			0: p = '{8'($urandom_range(0, 60)), 8'($urandom_range(150, 255)),
				8'($urandom_range(150, 255)), last};
			1: begin
				p.blue = 8'($urandom_range(0, 255));
				p.green = p.blue;
				p.red = p.blue;
			end
			2: p = '{$urandom_range(0, 1) ? 8'hFF : 8'h00, $urandom_range(0, 1) ? 8'hFF : 8'h00,
				$urandom_range(0, 1) ? 8'hFF : 8'h00, last};
			default: p = '{8'($urandom), 8'($urandom), 8'($urandom), last};
		endcase
		p.last = last;
		return p;
	endfunction

	task automatic queue_frame(int len);
		for (int i = 0; i < len; i++) pending_pixels.push_back(random_pixel(i == len - 1));
	endtask

	task automatic random_config(bit extreme);
		int c, r;
		c = extreme ? ($urandom_range(0, 1) ? 0 : 8191) : $urandom_range(1, 8);
		r = extreme ? ($urandom_range(0, 1) ? 0 : 8191) : $urandom_range(1, 6);
		write_reg(REG_FRAME_COLS, reg13(c));
		write_reg(REG_FRAME_ROWS, reg13(r));
		write_reg(REG_BOX_LEFT, reg13(extreme ? $urandom : $urandom_range(0, 8) - 2));
		write_reg(REG_BOX_TOP, reg13(extreme ? $urandom : $urandom_range(0, 6) - 2));
		write_reg(REG_BOX_WIDTH, reg13(extreme ? 8191 : $urandom_range(0, 9)));
		write_reg(REG_BOX_HEIGHT, reg13(extreme ? 8191 : $urandom_range(0, 7)));
		case ($urandom_range(0, 3))
			0: begin
				write_reg(REG_HSV_LOWER, 24'h000000);
				write_reg(REG_HSV_UPPER, 24'hFFFFFF);
			end
			1: begin
				write_reg(REG_HSV_LOWER, 24'd877668);
				write_reg(REG_HSV_UPPER, 24'd2223048);
			end
			2: begin
				write_reg(REG_HSV_LOWER, 24'($urandom) & 24'h7F7F7F);
				write_reg(REG_HSV_UPPER, 24'($urandom) | 24'h808080);
			end
			default: begin
				write_reg(REG_HSV_LOWER, 24'($urandom));
				write_reg(REG_HSV_UPPER, 24'($urandom));
			end
		endcase
	endtask

	function automatic int frame_length();
		int cols, rows, n;
		cols = fcols < 1 ? 1 : (fcols > LIMIT_COLS ? LIMIT_COLS : fcols);
		rows = frows < 1 ? 1 : (frows > LIMIT_ROWS ? LIMIT_ROWS : frows);
		n = (cols * rows > 40) ? $urandom_range(1, 40) : cols * rows;
		// sometimes cut the frame short or run past the last row
		case ($urandom_range(0, 5))
			0: n = $urandom_range(1, n);
			1: n = n + $urandom_range(1, 12);
			default: ;
		endcase
		return n;
	endfunction

	initial begin
		int phase;
		box_x = 0; box_y = 0; box_w = 0; box_h = 0;
		fcols = 640; frows = 480;
		lo_bound = 24'd877668; hi_bound = 24'd2223048;
		pos_col = 0; pos_row = 0;
		acc_cols = '0; acc_rows = '0; hit_count = '0;

		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// reset settings: zero-size box, so nothing can match
		queue_frame(3);
		settle();

		// directed: 3x3 frame, box covering all but the last row and column
		write_reg(REG_FRAME_COLS, 24'd3);
		write_reg(REG_FRAME_ROWS, 24'd3);
		write_reg(REG_BOX_LEFT, 24'h1F000);
		write_reg(REG_BOX_TOP, 24'h1F000);
		write_reg(REG_BOX_WIDTH, 24'd8191);
		write_reg(REG_BOX_HEIGHT, 24'd8191);
		write_reg(REG_HSV_LOWER, 24'h000000);
		write_reg(REG_HSV_UPPER, 24'hFFFFFF);
		pending_pixels.push_back('{8'h00, 8'h00, 8'h00, 1'b0});
		pending_pixels.push_back('{8'hFF, 8'hFF, 8'hFF, 1'b0});
		pending_pixels.push_back('{8'hFF, 8'h00, 8'h00, 1'b0});
		pending_pixels.push_back('{8'h00, 8'hFF, 8'h00, 1'b0});
		pending_pixels.push_back('{8'h00, 8'h00, 8'hFF, 1'b0});
		pending_pixels.push_back('{8'h80, 8'h01, 8'hFE, 1'b0});
		pending_pixels.push_back('{8'h10, 8'hC8, 8'hF0, 1'b0});
		pending_pixels.push_back('{8'hFE, 8'h7F, 8'h01, 1'b0});
		pending_pixels.push_back('{8'h01, 8'hFE, 8'h80, 1'b1});
		// a lone frame-end pixel, and one frame past the last row
		pending_pixels.push_back('{8'h33, 8'h44, 8'h55, 1'b1});
		queue_frame(14);
		settle();

		// extreme box start: past the border leaves an empty box
		write_reg(REG_BOX_LEFT, 24'd4095);
		queue_frame(4);
		settle();
		write_reg(REG_BOX_LEFT, 24'h1000);
		write_reg(REG_BOX_TOP, 24'd4095);
		queue_frame(4);
		settle();

		phase = 0;
		while (pixels_taken < 1750) begin
			random_config(phase % 9 == 4);
			// the last stretch runs with no idling on either side
			if (pixels_taken > 1550) quiet = 1'b1;
			if (phase == 6) begin
				// many short frames while the sink holds off, so the block backs up
				write_reg(REG_FRAME_COLS, 24'd2);
				write_reg(REG_FRAME_ROWS, 24'd2);
				hold_req = 1'b1;
				for (int f = 0; f < 12; f++) queue_frame($urandom_range(1, 3));
			end else begin
				for (int f = $urandom_range(1, 6); f > 0; f--) queue_frame(frame_length());
			end
			settle();
			phase++;
		end

		if (centroid_queue.size() != 0) begin
			$error("%0d centroid results never arrived", centroid_queue.size());
			fail_count++;
		end
		$display("Run covered %0d pixel beats over %0d frames, %0d with a blob found.",
			pixels_taken, frames_checked, frames_found);
		$display("Box, frame size and HSV bounds were changed over %0d random phases.", phase);
		if (fail_count == 0) begin
			$display("Verification passed");
		end else begin
			$display("Verification failed");
		end
		$finish;
	end

	initial begin
		#4ms;
		$display("Verification failed");
		$finish;
	end

endmodule
